/* hdl/spring_chain_acceleration_top_defines.svh */
// Assertion macros for the checker file.
`ifndef SPRING_CHAIN_ACCELERATION_TOP_DEFINES_SVH
`define SPRING_CHAIN_ACCELERATION_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SCAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scac check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SCAC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scac check failed");

`endif

/* hdl/scac_pkg.sv */
`timescale 1ns / 1ps
package scac_pkg;

  localparam int MAX_MASSES_DEF = 1024;
  localparam logic [31:0] GRAVITY_RST = 32'd642689;

  // 40-bit force limits
  localparam logic signed [39:0] FLIM = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] FMIN = 40'sh80_0000_0000;
  localparam logic signed [41:0] SUM_MAX = 42'sd549755813887;
  localparam logic signed [41:0] SUM_MIN = -42'sd549755813888;
  localparam logic [57:0] PROD_MAX = 58'd549755813887;

  // 32-bit acceleration limits
  localparam logic [31:0] ACC_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ACC_MIN = 32'h8000_0000;

  // Iteration counts of the root/divide unit
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS = 56;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] ext_force_x;
    logic signed [31:0] ext_force_y;
    logic [31:0]        mass_value;
    logic [31:0]        rest_length;
    logic [31:0]        stiffness;
    logic               last_mass;
  } mass_item_t;

  typedef struct packed {
    logic [9:0]         mass_index;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic               saturated;
    logic               last_result;
  } accel_item_t;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQ_SUM,
    ST_ROOT,
    ST_ROOT_WAIT,
    ST_DR,
    ST_TMUL,
    ST_TCLIP,
    ST_UX_WAIT,
    ST_FX_MUL,
    ST_FX_SET,
    ST_UY_WAIT,
    ST_FY_MUL,
    ST_FY_SET,
    ST_PEND,
    ST_AX,
    ST_AX_WAIT,
    ST_AY,
    ST_AY_WAIT,
    ST_EMIT,
    ST_WMUL,
    ST_WCLIP,
    ST_CFY,
    ST_CFY_W,
    ST_ANCHOR,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic               sat;
    logic signed [39:0] val;
  } sat40_t;

  // Saturating 40-bit add
  function automatic sat40_t add_sat(input logic signed [40:0] a,
                                     input logic signed [40:0] b);
    logic signed [41:0] s;
    sat40_t r;
    s = {a[40], a} + {b[40], b};
    if (s > SUM_MAX) begin
      r.sat = 1'b1;
      r.val = FLIM;
    end else if (s < SUM_MIN) begin
      r.sat = 1'b1;
      r.val = FMIN;
    end else begin
      r.sat = 1'b0;
      r.val = s[39:0];
    end
    return r;
  endfunction

  // Drop 16 fraction bits of a product and clip to the force limit
  function automatic sat40_t clip_q(input logic [73:0] p);
    sat40_t r;
    if (p[73:16] > PROD_MAX) begin
      r.sat = 1'b1;
      r.val = FLIM;
    end else begin
      r.sat = 1'b0;
      r.val = p[55:16];
    end
    return r;
  endfunction

endpackage

/* hdl/spring_chain_acceleration_top.sv */
`timescale 1ns / 1ps
// Accelerations of a 2D hanging mass-spring chain, Q16.16.
// Input channel mass_valid/mass_ready/mass_item: one item per mass, anchor
// first; last_mass closes the chain (an item at index MAX_MASSES-1 also does).
// Output channel accel_valid/accel_ready/accel_item: the acceleration of the
// previous mass once its second spring is known, and on the last item its own.
// gravity_we/gravity_wdata write the gravity register; write it
// only while the block is idle.
// One item is taken at a time; mass_ready is low until the item is finished.
// Cost is set by the shared root/divide unit, one result bit per cycle. An
// anchor needs no unit work; a middle mass needs one root, two direction
// divisions and two acceleration divisions; the last mass two more divisions.
// A zero distance skips the direction divisions, a zero mass skips its divisions.
// Results leave through one output register; while the receiver stalls the
// block waits with the next result, so nothing is lost.
// Reset (rst, synchronous) empties the output, restores gravity to 9.80665
// and makes the next item an anchor.
module spring_chain_acceleration_top #(
  parameter int MAX_MASSES = scac_pkg::MAX_MASSES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   mass_valid,
  output logic                   mass_ready,
  input  scac_pkg::mass_item_t   mass_item,
  output logic                   accel_valid,
  input  logic                   accel_ready,
  output scac_pkg::accel_item_t  accel_item,
  input  logic                   gravity_we,
  input  logic [31:0]            gravity_wdata
);

  localparam int CNT_W = $clog2(MAX_MASSES);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_MASSES - 1);

  scac_pkg::seq_state_t state, state_next;

  // chain state
  logic [CNT_W-1:0]   count;
  logic signed [31:0] prev_x, prev_y;
  logic signed [39:0] pend_x, pend_y;
  logic               psat;
  logic [31:0]        prev_mass;
  logic [31:0]        gravity;

  // per-item working registers
  scac_pkg::mass_item_t in_r;
  logic               last_r;
  logic               csat;
  logic               acc_cur;
  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  logic [65:0]        sq;
  logic [32:0]        span;
  logic               dr_pos;
  logic [33:0]        adr;
  logic [39:0]        tq;
  logic [16:0]        uq;
  logic signed [39:0] fx, fy;
  logic signed [39:0] pfx, pfy, cfx, cfy;
  logic [39:0]        wt;
  logic signed [31:0] ax, ay;

  // shared units
  scac_pkg::unit_ctl_t  u_ctl;
  scac_pkg::unit_stat_t u_stat;
  logic [65:0]          u_src;
  logic [33:0]          u_den;
  logic [55:0]          u_res;
  logic [39:0]          mul_a;
  logic [33:0]          mul_b;
  logic [73:0]          mul_p;

  scac_iter u_iter (
    .clk  (clk),
    .rst  (rst),
    .ctl  (u_ctl),
    .src  (u_src),
    .den  (u_den),
    .stat (u_stat),
    .res  (u_res)
  );

  scac_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // helpers
  logic               accept;
  logic               last_now;
  logic               out_free;
  logic signed [32:0] dx_w, dy_w;
  logic signed [33:0] dr_w;
  logic               f_on_y;
  logic signed [39:0] f_sel;
  logic [39:0]        f_mag;
  logic [31:0]        m_sel;
  logic               q_over;
  logic [31:0]        acc_val;
  logic               fneg;
  logic [39:0]        prod_mag;
  logic [CNT_W-1:0]   emit_idx;
  logic [31:0]        idx32;
  scac_pkg::sat40_t   clip_r;
  scac_pkg::sat40_t   sum_a, sum_b;

  assign accept   = mass_valid && mass_ready;
  assign last_now = mass_item.last_mass || (count >= LAST_IDX);
  assign out_free = !accel_valid || accel_ready;

  // Operand selection for the accel divisions, and the other datapath helpers
  always_comb begin
    dx_w     = {in_r.pos_x[31], in_r.pos_x} - {prev_x[31], prev_x};
    dy_w     = {in_r.pos_y[31], in_r.pos_y} - {prev_y[31], prev_y};
    dr_w     = {1'b0, span} - {2'b0, in_r.rest_length};
    f_on_y   = (state == scac_pkg::ST_AY) || (state == scac_pkg::ST_AY_WAIT);
    f_sel    = acc_cur ? (f_on_y ? cfy : cfx) : (f_on_y ? pfy : pfx);
    m_sel    = acc_cur ? in_r.mass_value : prev_mass;
    f_mag    = f_sel[39] ? 40'(-f_sel) : 40'(f_sel);
    q_over   = |u_res[55:31];
    if (m_sel == 32'd0) begin
      if (f_sel[39]) begin
        acc_val = scac_pkg::ACC_MIN;
      end else if (f_sel != 40'sd0) begin
        acc_val = scac_pkg::ACC_MAX;
      end else begin
        acc_val = 32'd0;
      end
    end else if (q_over) begin
      acc_val = f_sel[39] ? scac_pkg::ACC_MIN : scac_pkg::ACC_MAX;
    end else begin
      acc_val = f_sel[39] ? 32'(-u_res[31:0]) : u_res[31:0];
    end
    prod_mag = mul_p[55:16];
    emit_idx = acc_cur ? count : count - 1'b1;
    idx32    = 32'(emit_idx);
    clip_r   = scac_pkg::clip_q(mul_p);
  end

  // Sign of the spring component on the current mass
  always_comb begin
    if (state == scac_pkg::ST_FX_SET) begin
      fneg = (dx != 33'sd0) && ((!dx[32]) == dr_pos);
    end else begin
      fneg = (dy != 33'sd0) && ((!dy[32]) == dr_pos);
    end
  end

  // Force sums, chosen by step
  always_comb begin
    case (state)
      scac_pkg::ST_PEND: begin
        sum_a = scac_pkg::add_sat({pend_x[39], pend_x}, -{fx[39], fx});
        sum_b = scac_pkg::add_sat({pend_y[39], pend_y}, -{fy[39], fy});
      end
      scac_pkg::ST_WCLIP: begin
        sum_a = scac_pkg::add_sat(41'(in_r.ext_force_x), {fx[39], fx});
        sum_b = sum_a;
      end
      scac_pkg::ST_CFY: begin
        sum_a = scac_pkg::add_sat(41'(in_r.ext_force_y), {fy[39], fy});
        sum_b = sum_a;
      end
      default: begin
        sum_a = scac_pkg::add_sat({cfy[39], cfy}, -{1'b0, wt});
        sum_b = sum_a;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, unit control and multiplier operands
  always_comb begin
    state_next = state;
    mass_ready = 1'b0;
    u_ctl      = '{start: 1'b0, op: scac_pkg::OP_DIV};
    u_src      = {7'b0, adx, 26'b0};
    u_den      = {1'b0, span};
    mul_a      = {7'b0, adx};
    mul_b      = {1'b0, adx};
    case (state)
      scac_pkg::ST_IDLE: begin
        mass_ready = 1'b1;
        if (mass_valid) begin
          if (count == '0) begin
            state_next = last_now ? scac_pkg::ST_ANCHOR : scac_pkg::ST_FINISH;
          end else begin
            state_next = scac_pkg::ST_DIFF;
          end
        end
      end
      scac_pkg::ST_DIFF:   state_next = scac_pkg::ST_SQ_A;
      scac_pkg::ST_SQ_A:   state_next = scac_pkg::ST_SQ_B;
      scac_pkg::ST_SQ_B: begin
        mul_a      = {7'b0, ady};
        mul_b      = {1'b0, ady};
        state_next = scac_pkg::ST_SQ_SUM;
      end
      scac_pkg::ST_SQ_SUM: state_next = scac_pkg::ST_ROOT;
      scac_pkg::ST_ROOT: begin
        u_ctl      = '{start: 1'b1, op: scac_pkg::OP_SQRT};
        u_src      = sq;
        state_next = scac_pkg::ST_ROOT_WAIT;
      end
      scac_pkg::ST_ROOT_WAIT: begin
        if (u_stat.done) begin
          state_next = (u_res[32:0] == 33'd0) ? scac_pkg::ST_PEND : scac_pkg::ST_DR;
        end
      end
      scac_pkg::ST_DR:     state_next = scac_pkg::ST_TMUL;
      scac_pkg::ST_TMUL: begin
        mul_a      = {8'b0, in_r.stiffness};
        mul_b      = adr;
        state_next = scac_pkg::ST_TCLIP;
      end
      scac_pkg::ST_TCLIP: begin
        u_ctl      = '{start: 1'b1, op: scac_pkg::OP_DIV};
        u_src      = {7'b0, adx, 26'b0};
        state_next = scac_pkg::ST_UX_WAIT;
      end
      scac_pkg::ST_UX_WAIT: begin
        if (u_stat.done) state_next = scac_pkg::ST_FX_MUL;
      end
      scac_pkg::ST_FX_MUL: begin
        u_ctl      = '{start: 1'b1, op: scac_pkg::OP_DIV};
        u_src      = {7'b0, ady, 26'b0};
        mul_a      = tq;
        mul_b      = {17'b0, uq};
        state_next = scac_pkg::ST_FX_SET;
      end
      scac_pkg::ST_FX_SET: state_next = scac_pkg::ST_UY_WAIT;
      scac_pkg::ST_UY_WAIT: begin
        if (u_stat.done) state_next = scac_pkg::ST_FY_MUL;
      end
      scac_pkg::ST_FY_MUL: begin
        mul_a      = tq;
        mul_b      = {17'b0, uq};
        state_next = scac_pkg::ST_FY_SET;
      end
      scac_pkg::ST_FY_SET: state_next = scac_pkg::ST_PEND;
      scac_pkg::ST_PEND: begin
        state_next = (count == CNT_W'(1)) ? scac_pkg::ST_EMIT : scac_pkg::ST_AX;
      end
      scac_pkg::ST_AX, scac_pkg::ST_AY: begin
        u_src = {f_mag, 26'b0};
        u_den = {2'b0, m_sel};
        if (m_sel == 32'd0) begin
          state_next = (state == scac_pkg::ST_AX) ? scac_pkg::ST_AY : scac_pkg::ST_EMIT;
        end else begin
          u_ctl      = '{start: 1'b1, op: scac_pkg::OP_DIV};
          state_next = (state == scac_pkg::ST_AX) ? scac_pkg::ST_AX_WAIT
                                                   : scac_pkg::ST_AY_WAIT;
        end
      end
      scac_pkg::ST_AX_WAIT: begin
        if (u_stat.done) state_next = scac_pkg::ST_AY;
      end
      scac_pkg::ST_AY_WAIT: begin
        if (u_stat.done) state_next = scac_pkg::ST_EMIT;
      end
      scac_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = acc_cur ? scac_pkg::ST_FINISH : scac_pkg::ST_WMUL;
        end
      end
      scac_pkg::ST_WMUL: begin
        mul_a      = {8'b0, in_r.mass_value};
        mul_b      = {2'b0, gravity};
        state_next = scac_pkg::ST_WCLIP;
      end
      scac_pkg::ST_WCLIP:  state_next = scac_pkg::ST_CFY;
      scac_pkg::ST_CFY:    state_next = scac_pkg::ST_CFY_W;
      scac_pkg::ST_CFY_W: begin
        state_next = last_r ? scac_pkg::ST_AX : scac_pkg::ST_FINISH;
      end
      scac_pkg::ST_ANCHOR: begin
        if (out_free) state_next = scac_pkg::ST_FINISH;
      end
      scac_pkg::ST_FINISH: state_next = scac_pkg::ST_IDLE;
      default:             state_next = scac_pkg::ST_IDLE;
    endcase
  end

  // Chain state and gravity register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      prev_x    <= '0;
      prev_y    <= '0;
      pend_x    <= '0;
      pend_y    <= '0;
      psat      <= 1'b0;
      prev_mass <= '0;
      gravity   <= scac_pkg::GRAVITY_RST;
    end else begin
      if (gravity_we) gravity <= gravity_wdata;
      case (state)
        scac_pkg::ST_TCLIP: begin
          if (clip_r.sat) psat <= 1'b1;
        end
        scac_pkg::ST_PEND: begin
          if (count == CNT_W'(1)) begin
            psat <= 1'b0;
          end else if (sum_a.sat || sum_b.sat) begin
            psat <= 1'b1;
          end
        end
        scac_pkg::ST_AX, scac_pkg::ST_AY: begin
          if (m_sel == 32'd0 && !acc_cur) psat <= 1'b1;
        end
        scac_pkg::ST_AX_WAIT, scac_pkg::ST_AY_WAIT: begin
          if (u_stat.done && q_over && !acc_cur) psat <= 1'b1;
        end
        scac_pkg::ST_FINISH: begin
          prev_x <= in_r.pos_x;
          prev_y <= in_r.pos_y;
          if (last_r) begin
            count     <= '0;
            pend_x    <= '0;
            pend_y    <= '0;
            psat      <= 1'b0;
            prev_mass <= '0;
          end else if (count == '0) begin
            count <= CNT_W'(1);
          end else begin
            pend_x    <= cfx;
            pend_y    <= cfy;
            psat      <= csat;
            prev_mass <= in_r.mass_value;
            count     <= count + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Per-item datapath
  always_ff @(posedge clk) begin
    case (state)
      scac_pkg::ST_IDLE: begin
        if (accept) begin
          in_r   <= mass_item;
          last_r <= last_now;
          csat   <= 1'b0;
          fx     <= '0;
          fy     <= '0;
        end
      end
      scac_pkg::ST_DIFF: begin
        dx  <= dx_w;
        dy  <= dy_w;
        adx <= dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
        ady <= dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
      end
      scac_pkg::ST_SQ_B:   sq <= mul_p[65:0];
      scac_pkg::ST_SQ_SUM: sq <= sq + mul_p[65:0];
      scac_pkg::ST_ROOT_WAIT: begin
        if (u_stat.done) span <= u_res[32:0];
      end
      scac_pkg::ST_DR: begin
        dr_pos <= !dr_w[33] && (dr_w != 34'sd0);
        adr    <= dr_w[33] ? 34'(-dr_w) : 34'(dr_w);
      end
      scac_pkg::ST_TCLIP: begin
        tq <= clip_r.val;
        if (clip_r.sat) csat <= 1'b1;
      end
      scac_pkg::ST_UX_WAIT, scac_pkg::ST_UY_WAIT: begin
        if (u_stat.done) uq <= u_res[16:0];
      end
      scac_pkg::ST_FX_SET: fx <= fneg ? -prod_mag : prod_mag;
      scac_pkg::ST_FY_SET: fy <= fneg ? -prod_mag : prod_mag;
      scac_pkg::ST_PEND: begin
        acc_cur <= 1'b0;
        ax      <= '0;
        ay      <= '0;
        pfx     <= sum_a.val;
        pfy     <= sum_b.val;
      end
      scac_pkg::ST_AX: begin
        if (m_sel == 32'd0) begin
          ax <= acc_val;
          if (acc_cur) csat <= 1'b1;
        end
      end
      scac_pkg::ST_AY: begin
        if (m_sel == 32'd0) begin
          ay <= acc_val;
          if (acc_cur) csat <= 1'b1;
        end
      end
      scac_pkg::ST_AX_WAIT: begin
        if (u_stat.done) begin
          ax <= acc_val;
          if (q_over && acc_cur) csat <= 1'b1;
        end
      end
      scac_pkg::ST_AY_WAIT: begin
        if (u_stat.done) begin
          ay <= acc_val;
          if (q_over && acc_cur) csat <= 1'b1;
        end
      end
      scac_pkg::ST_WCLIP: begin
        wt  <= clip_r.val;
        cfx <= sum_a.val;
        if (clip_r.sat || sum_a.sat) csat <= 1'b1;
      end
      scac_pkg::ST_CFY: begin
        cfy <= sum_a.val;
        if (sum_a.sat) csat <= 1'b1;
      end
      scac_pkg::ST_CFY_W: begin
        cfy     <= sum_a.val;
        acc_cur <= 1'b1;
        if (sum_a.sat) csat <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register: load a finished item when free, drop on take
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_valid <= 1'b0;
    end else begin
      if (out_free && state == scac_pkg::ST_EMIT) begin
        accel_valid            <= 1'b1;
        accel_item.mass_index  <= idx32[9:0];
        accel_item.accel_x     <= ax;
        accel_item.accel_y     <= ay;
        accel_item.saturated   <= acc_cur ? csat : psat;
        accel_item.last_result <= acc_cur;
      end else if (out_free && state == scac_pkg::ST_ANCHOR) begin
        accel_valid            <= 1'b1;
        accel_item.mass_index  <= '0;
        accel_item.accel_x     <= '0;
        accel_item.accel_y     <= '0;
        accel_item.saturated   <= 1'b0;
        accel_item.last_result <= 1'b1;
      end else if (accel_ready) begin
        accel_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/scac_iter.sv */
`timescale 1ns / 1ps
module scac_iter (
  input  logic                  clk,
  input  logic                  rst,
  input  scac_pkg::unit_ctl_t   ctl,
  input  logic [65:0]           src,
  input  logic [33:0]           den,
  output scac_pkg::unit_stat_t  stat,
  output logic [55:0]           res
);

  logic [5:0]         cnt;
  logic [37:0]        rem;
  logic [55:0]        acc;
  logic [65:0]        sh;
  logic [33:0]        dn;
  scac_pkg::unit_op_t op_r;
  logic               busy;
  logic               done;

  logic [37:0] rem2;
  logic [37:0] trial;
  logic [37:0] diff;
  logic        ge;

  // One restoring step: two bits for a root, one bit for a quotient
  always_comb begin
    if (op_r == scac_pkg::OP_SQRT) begin
      rem2  = {rem[35:0], sh[65:64]};
      trial = {acc[35:0], 2'b01};
    end else begin
      rem2  = {rem[36:0], sh[65]};
      trial = {4'b0, dn};
    end
    ge   = rem2 >= trial;
    diff = rem2 - trial;
  end

  // Load operands on start, then step until the count runs out
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        op_r <= ctl.op;
        sh   <= src;
        dn   <= den;
        rem  <= '0;
        acc  <= '0;
        cnt  <= (ctl.op == scac_pkg::OP_SQRT) ? 6'(scac_pkg::SQRT_STEPS - 1)
                                              : 6'(scac_pkg::DIV_STEPS - 1);
      end else if (busy) begin
        rem <= ge ? diff : rem2;
        acc <= {acc[54:0], ge};
        sh  <= (op_r == scac_pkg::OP_SQRT) ? {sh[63:0], 2'b00} : {sh[64:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign res       = acc;

endmodule

/* hdl/scac_mul.sv */
`timescale 1ns / 1ps
module scac_mul (
  input  logic        clk,
  input  logic [39:0] a,
  input  logic [33:0] b,
  output logic [73:0] p
);

  // Register the product
  always_ff @(posedge clk) begin
    p <= 74'(a) * 74'(b);
  end

endmodule

/* hdl/scac_check.sv */
`timescale 1ns / 1ps
`include "spring_chain_acceleration_top_defines.svh"
module scac_check (
  input logic                  clk,
  input logic                  rst,
  input logic                  mass_valid,
  input logic                  mass_ready,
  input logic                  accel_valid,
  input logic                  accel_ready,
  input scac_pkg::accel_item_t accel_item
);

  // A stalled result item holds
  `SCAC_ASSERT_NXT(a_out_hold, accel_valid && !accel_ready, accel_valid && $stable(accel_item))

  // One item at a time: ready drops after an accept
  `SCAC_ASSERT_NXT(a_one_item, mass_valid && mass_ready, !mass_ready)

  // A new result appears only while an item is being worked
  `SCAC_ASSERT_IMP(a_rise_busy, $rose(accel_valid), !mass_ready)

  // Output is empty right after reset
  `SCAC_ASSERT_IMP(a_rst_empty, $past(rst), !accel_valid)

endmodule

bind spring_chain_acceleration_top scac_check u_scac_check (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;

  localparam int CHAIN_MAX = scac_pkg::MAX_MASSES_DEF;
  localparam longint FORCE_HI = 64'sd549755813887;
  localparam longint FORCE_LO = -64'sd549755813888;
  localparam longint CYCLE_LIMIT = 64'd6000000;

  logic clk = 1'b0;
  logic rst;
  logic mass_valid;
  logic mass_ready;
  scac_pkg::mass_item_t mass_item;
  logic accel_valid;
  logic accel_ready;
  scac_pkg::accel_item_t accel_item;
  logic gravity_we;
  logic [31:0] gravity_wdata;

  spring_chain_acceleration_top u_top (
    .clk(clk), .rst(rst),
    .mass_valid(mass_valid), .mass_ready(mass_ready), .mass_item(mass_item),
    .accel_valid(accel_valid), .accel_ready(accel_ready), .accel_item(accel_item),
    .gravity_we(gravity_we), .gravity_wdata(gravity_wdata)
  );

  always #2 clk = ~clk;

  // Expected accelerations, oldest first
  scac_pkg::accel_item_t accel_expect_q[$];
  int mismatch_count = 0;
  int items_sent = 0;
  int accels_checked = 0;
  longint cycle_count = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int gravity_writes = 0;

  // Chain state of the predictor
  bit [31:0] grav_q;
  longint last_px, last_py, held_fx, held_fy;
  bit held_sat;
  bit [31:0] held_mass;
  int chain_pos;

  // Previous position driven, used to make zero-length springs
  logic signed [31:0] drv_px, drv_py;

  function automatic bit [33:0] chain_root(bit [65:0] v);
    bit [33:0] r;
    bit [33:0] tr;
    r = '0;
    for (int i = 32; i >= 0; i--) begin
      tr = r | (34'd1 << i);
      if ({34'b0, tr} * {34'b0, tr} <= {2'b0, v}) r = tr;
    end
    return r;
  endfunction

  // floor(a*b/2^16), clipped to the force limit
  function automatic longint scaled_product(bit [31:0] a, bit [35:0] b, inout bit sat);
    bit [67:0] p;
    p = ({36'b0, a} * {32'b0, b}) >> 16;
    if (p > 68'(FORCE_HI)) begin
      sat = 1'b1;
      return FORCE_HI;
    end
    return longint'(p);
  endfunction

  function automatic longint force_sum(longint a, longint b, inout bit sat);
    longint s;
    s = a + b;
    if (s > FORCE_HI) begin
      sat = 1'b1;
      return FORCE_HI;
    end
    if (s < FORCE_LO) begin
      sat = 1'b1;
      return FORCE_LO;
    end
    return s;
  endfunction

  // Spring force along one axis; pulls toward rest length
  function automatic longint axis_force(longint t, longint d, bit [33:0] span,
                                        bit stretched);
    bit [63:0] ad;
    bit [63:0] u;
    longint m;
    ad = (d < 0) ? -d : d;
    u = (ad << 16) / {30'b0, span};
    m = longint'((t * u) >> 16);
    return ((d != 0) && ((d > 0) == stretched)) ? -m : m;
  endfunction

  function automatic logic signed [31:0] accel_of(longint f, bit [31:0] m, inout bit sat);
    bit [63:0] af;
    bit [63:0] q;
    if (m == 0) begin
      sat = 1'b1;
      return (f > 0) ? scac_pkg::ACC_MAX : ((f < 0) ? scac_pkg::ACC_MIN : 32'd0);
    end
    af = (f < 0) ? -f : f;
    q = (af << 16) / {32'b0, m};
    if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      q = (f < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
    end
    return (f < 0) ? -q[31:0] : q[31:0];
  endfunction

  function automatic void push_accel(int idx, logic [31:0] ax, logic [31:0] ay,
                                     bit sat, bit fin);
    scac_pkg::accel_item_t a;
    a.mass_index = idx[9:0];
    a.accel_x = ax;
    a.accel_y = ay;
    a.saturated = sat;
    a.last_result = fin;
    accel_expect_q.push_back(a);
  endfunction

  function automatic void chain_clear();
    last_px = 0;
    last_py = 0;
    held_fx = 0;
    held_fy = 0;
    held_sat = 0;
    held_mass = 0;
    chain_pos = 0;
  endfunction

  // Work out the accelerations that one mass releases
  function automatic void predict_accels(scac_pkg::mass_item_t it);
    longint px, py, dx, dy, dr, t, fx, fy, cfx, cfy, wt, pfx, pfy, adr;
    bit [32:0] adx, ady;
    bit [33:0] span;
    bit fin, csat, psat, tsat;
    logic [31:0] ax, ay;
    px = longint'($signed(it.pos_x));
    py = longint'($signed(it.pos_y));
    fin = it.last_mass || (chain_pos >= CHAIN_MAX - 1);
    if (chain_pos == 0) begin
      if (fin) push_accel(0, 0, 0, 1'b0, 1'b1);
      else chain_pos = 1;
    end else begin
      csat = 0;
      psat = held_sat;
      tsat = 0;
      fx = 0;
      fy = 0;
      dx = px - last_px;
      dy = py - last_py;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      span = chain_root({33'b0, adx} * {33'b0, adx} + {33'b0, ady} * {33'b0, ady});
      if (span != 0) begin
        dr = longint'(span) - longint'(it.rest_length);
        adr = (dr < 0) ? -dr : dr;
        t = scaled_product(it.stiffness, adr[35:0], tsat);
        fx = axis_force(t, dx, span, dr > 0);
        fy = axis_force(t, dy, span, dr > 0);
        if (tsat) begin
          csat = 1;
          psat = 1;
        end
      end
      if (chain_pos == 1) begin
        push_accel(0, 0, 0, 1'b0, 1'b0);
      end else begin
        pfx = force_sum(held_fx, -fx, psat);
        pfy = force_sum(held_fy, -fy, psat);
        ax = accel_of(pfx, held_mass, psat);
        ay = accel_of(pfy, held_mass, psat);
        push_accel(chain_pos - 1, ax, ay, psat, 1'b0);
      end
      wt = scaled_product(it.mass_value, {4'b0, grav_q}, csat);
      cfx = force_sum(longint'($signed(it.ext_force_x)), fx, csat);
      cfy = force_sum(longint'($signed(it.ext_force_y)), fy, csat);
      cfy = force_sum(cfy, -wt, csat);
      if (fin) begin
        ax = accel_of(cfx, it.mass_value, csat);
        ay = accel_of(cfy, it.mass_value, csat);
        push_accel(chain_pos, ax, ay, csat, 1'b1);
      end else begin
        held_fx = cfx;
        held_fy = cfy;
        held_sat = csat;
        held_mass = it.mass_value;
        chain_pos++;
      end
    end
    if (fin) chain_clear();
    last_px = px;
    last_py = py;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want,
               accels_checked);
  endtask

  // Drive one mass and hold it until it is taken
  task automatic send_mass(scac_pkg::mass_item_t it);
    if (idle_on && ($urandom_range(0, 3) == 0)) begin
      mass_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    mass_valid <= 1'b1;
    mass_item <= it;
    predict_accels(it);
    drv_px = it.pos_x;
    drv_py = it.pos_y;
    items_sent++;
    do @(posedge clk); while (!mass_ready);
  endtask

  task automatic wait_idle();
    mass_valid <= 1'b0;
    while (accel_expect_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_gravity(logic [31:0] g);
    wait_idle();
    gravity_we <= 1'b1;
    gravity_wdata <= g;
    @(posedge clk);
    gravity_we <= 1'b0;
    grav_q = g;
    gravity_writes++;
  endtask

  function automatic logic [31:0] corner_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] near_word(int span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  // Styles: 0 plausible chain, 1 full random, 2 corner values
  function automatic scac_pkg::mass_item_t random_mass(int style, bit fin);
    scac_pkg::mass_item_t it;
    case (style)
      0: begin
        if ($urandom_range(0, 9) == 0) begin
          it.pos_x = drv_px;
          it.pos_y = drv_py;
        end else begin
          it.pos_x = near_word(8 << 16);
          it.pos_y = near_word(8 << 16);
        end
        it.ext_force_x = near_word(4 << 16);
        it.ext_force_y = near_word(4 << 16);
        it.mass_value = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom_range(1, 6 << 16);
        it.rest_length = $urandom_range(0, 4 << 16);
        it.stiffness = $urandom_range(0, 200 << 16);
      end
      1: begin
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.ext_force_x = $urandom;
        it.ext_force_y = $urandom;
        it.mass_value = $urandom;
        it.rest_length = $urandom;
        it.stiffness = $urandom;
      end
      default: begin
        it.pos_x = corner_word();
        it.pos_y = corner_word();
        it.ext_force_x = corner_word();
        it.ext_force_y = corner_word();
        it.mass_value = corner_word();
        it.rest_length = corner_word();
        it.stiffness = corner_word();
      end
    endcase
    it.last_mass = fin;
    return it;
  endfunction

  function automatic scac_pkg::mass_item_t plain_mass(int x, int y, logic [31:0] m,
                                                       bit fin);
    scac_pkg::mass_item_t it;
    it.pos_x = x;
    it.pos_y = y;
    it.ext_force_x = 0;
    it.ext_force_y = 0;
    it.mass_value = m;
    it.rest_length = 32'h0001_0000;
    it.stiffness = 32'h000A_0000;
    it.last_mass = fin;
    return it;
  endfunction

  // Send a chain of n masses with a given style
  task automatic send_chain(int n, int style);
    for (int i = 0; i < n; i++) send_mass(random_mass(style, i == n - 1));
  endtask

  // Anchor as the whole chain, fields at their extremes
  task automatic test_lone_anchor();
    scac_pkg::mass_item_t it;
    it = '1;
    send_mass(it);
    it = '0;
    it.last_mass = 1'b1;
    send_mass(it);
  endtask

  // Zero-length spring, zero mass, clipped force and corner positions
  task automatic test_special_cases();
    scac_pkg::mass_item_t it;
    send_mass(plain_mass(0, 0, 32'h0001_0000, 1'b0));
    send_mass(plain_mass(0, 0, 32'h0001_0000, 1'b0));
    send_mass(plain_mass(0, -65536, 32'd0, 1'b0));
    send_mass(plain_mass(3 << 16, -(4 << 16), 32'h0002_0000, 1'b0));
    it = plain_mass(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    it.stiffness = 32'hFFFF_FFFF;
    it.ext_force_x = 32'sh7FFF_FFFF;
    it.ext_force_y = 32'sh8000_0000;
    send_mass(it);
    it = plain_mass(32'sh8000_0000, 32'sh8000_0000, 32'h0000_0001, 1'b0);
    it.stiffness = 32'hFFFF_FFFF;
    it.rest_length = 32'hFFFF_FFFF;
    send_mass(it);
    it = plain_mass(32'sh8000_0000, 32'sh7FFF_FFFF, 32'd0, 1'b1);
    it.ext_force_x = 32'sh8000_0000;
    send_mass(it);
    send_mass(plain_mass(0, 0, 32'h0001_0000, 1'b0));
    send_mass(plain_mass(0, 0, 32'd0, 1'b1));
  endtask

  // Gravity at zero, at full scale and at a random value
  task automatic test_gravity_range();
    write_gravity(32'd0);
    send_chain(4, 0);
    write_gravity(32'hFFFF_FFFF);
    send_chain(4, 0);
    send_chain(3, 2);
    write_gravity($urandom);
    send_chain(5, 0);
    write_gravity(scac_pkg::GRAVITY_RST);
  endtask

  // Chain with no end mark: the block closes it at its maximum length
  task automatic test_overlong_chain();
    wait_idle();
    for (int i = 0; i < CHAIN_MAX; i++) send_mass(random_mass(0, 1'b0));
    send_chain(2, 0);
  endtask

  task automatic test_random_chains(int budget);
    int n;
    int style;
    int r;
    while (budget > 0) begin
      idle_on = ($urandom_range(0, 4) != 0);
      r = $urandom_range(0, 9);
      style = (r < 6) ? 0 : ((r < 8) ? 1 : 2);
      n = $urandom_range(1, 10);
      send_chain(n, style);
      budget -= n;
      if ($urandom_range(0, 40) == 0) write_gravity($urandom_range(0, 20 << 16));
    end
  endtask

  task automatic test_quiet_tail();
    idle_on = 1'b0;
    for (int i = 0; i < 8; i++) send_chain($urandom_range(1, 6), 0);
  endtask

  // Receiver: random stall bursts, then compare each result with the oldest expected
  always @(posedge clk) begin
    if (rst) begin
      accel_ready <= 1'b1;
    end else begin
      if (accel_valid && accel_ready) begin
        if (accel_expect_q.size() == 0) begin
          report_mismatch("unexpected result, index", accel_item.mass_index, -1);
        end else begin
          scac_pkg::accel_item_t e;
          e = accel_expect_q.pop_front();
          if (accel_item.mass_index !== e.mass_index)
            report_mismatch("mass_index", accel_item.mass_index, e.mass_index);
          if (accel_item.accel_x !== e.accel_x)
            report_mismatch("accel_x", $signed(accel_item.accel_x), $signed(e.accel_x));
          if (accel_item.accel_y !== e.accel_y)
            report_mismatch("accel_y", $signed(accel_item.accel_y), $signed(e.accel_y));
          if (accel_item.saturated !== e.saturated)
            report_mismatch("saturated", accel_item.saturated, e.saturated);
          if (accel_item.last_result !== e.last_result)
            report_mismatch("last_result", accel_item.last_result, e.last_result);
        end
        accels_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        accel_ready <= 1'b0;
      end else if (idle_on && ($urandom_range(0, 5) == 0)) begin
        stall_left = $urandom_range(0, 3);
        accel_ready <= 1'b0;
      end else begin
        accel_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    mass_valid <= 1'b0;
    mass_item <= '0;
    gravity_we <= 1'b0;
    gravity_wdata <= '0;
    grav_q = scac_pkg::GRAVITY_RST;
    drv_px = 0;
    drv_py = 0;
    chain_clear();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_lone_anchor();
    test_special_cases();
    test_gravity_range();
    test_random_chains(420);
    test_overlong_chain();
    test_random_chains(60);
    test_quiet_tail();

    wait_idle();
    $display("sent %0d masses, checked %0d accelerations, %0d gravity writes",
             items_sent, accels_checked, gravity_writes);
    $display("covered lone anchors, zero springs, zero masses, clipping, overlong chain");
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/scac_pkg.sv
hdl/scac_iter.sv
hdl/scac_mul.sv
hdl/spring_chain_acceleration_top.sv
hdl/scac_check.sv
tb/sv/testbench.sv
